[rtl/xeu_pkg.sv]
// Package for the XML entity unescape unit: shared types, character
// constants and the small entity name and digit lookup functions.
// No dependencies.
package xeu_pkg;

  localparam int unsigned LIMIT_W   = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 10'd319;
  localparam int unsigned NAME_CNT  = 5;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_SAT = 8'd128;

  typedef enum logic {
    KIND_BYTE,
    KIND_EOL
  } item_kind_e;

  typedef enum logic [2:0] {
    NM_AMP,
    NM_LT,
    NM_GT,
    NM_QUOT,
    NM_APOS
  } name_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       line_done;
  } res_t;

  // back end to output stage
  typedef struct packed {
    logic fire;
    logic res_v;
    res_t res;
    logic done;
  } back_ctl_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic logic [2:0] name_len(name_e n);
    logic [2:0] len;
    case (n)
      NM_AMP:  len = 3'd3;
      NM_LT:   len = 3'd2;
      NM_GT:   len = 3'd2;
      NM_QUOT: len = 3'd4;
      NM_APOS: len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] name_char(name_e n, logic [1:0] pos);
    logic [31:0] s;
    case (n)
      NM_AMP:  s = {"amp", 8'h00};
      NM_LT:   s = {"lt", 16'h0000};
      NM_GT:   s = {"gt", 16'h0000};
      NM_QUOT: s = "quot";
      NM_APOS: s = "apos";
      default: s = 32'h0;
    endcase
    return s[{~pos, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] name_value(name_e n);
    logic [7:0] v;
    case (n)
      NM_AMP:  v = 8'h26;
      NM_LT:   v = 8'h3C;
      NM_GT:   v = 8'h3E;
      NM_QUOT: v = 8'h22;
      NM_APOS: v = 8'h27;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic digit_t digit_of(logic [7:0] c, logic hex);
    digit_t d;
    d = '0;
    if (c inside {[8'h30:8'h39]}) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'h30);
    end else if (hex && (c inside {[8'h61:8'h66]})) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'h57);
    end else if (hex && (c inside {[8'h41:8'h46]})) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'h37);
    end
    return d;
  endfunction

endpackage

[rtl/xml_entity_unescape_unit.sv]
// Top level of the XML entity unescape unit: output limit register and
// the front queue, entity back end and output stage.
// Depends on xeu_pkg, xeu_front, xeu_back, xeu_out.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid_i, in_stall_o | byte_value_i, end_of_line_i
//   out     | out_valid_o, out_stall_i | byte_out_o, byte_valid_o, line_done_o, last_o
//   cfg     | cfg_we_i               | cfg_wdata_i (output_limit)
//
// The back end handles one byte per cycle while the output stage does not block it,
// and a line end marker is one more item. A failed entity emits its '&' and replays up
// to MAX_NAME + 1 stored bytes, one per cycle; failures found while replaying nest. A
// line end emits the '&' of each open entity it flushes and replays its name. The
// 2-deep input queue stalls only when full; each result passes through the hold
// register and then the output register before it is valid at the outputs.
module xml_entity_unescape_unit #(
  parameter int unsigned MAX_NAME = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [xeu_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  byte_value_i,
  input  logic                        end_of_line_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  byte_out_o,
  output logic                        byte_valid_o,
  output logic                        line_done_o,
  output logic                        last_o
);
  import xeu_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               item_valid, pop, block;
  item_t              item;
  back_ctl_t          ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  xeu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_value_i  (byte_value_i),
    .end_of_line_i (end_of_line_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .pop_i         (pop)
  );

  xeu_back #(
    .MAX_NAME (MAX_NAME)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .limit_i      (limit_q),
    .block_i      (block),
    .ctl_o        (ctl)
  );

  xeu_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .block_o      (block),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_out_o   (byte_out_o),
    .byte_valid_o (byte_valid_o),
    .line_done_o  (line_done_o),
    .last_o       (last_o)
  );

endmodule

[rtl/xeu_front.sv]
// Front end of the XML entity unescape unit: accepts input beats,
// tags them as byte or line end and queues them in a two-entry FIFO.
// Depends on xeu_pkg.
module xeu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    byte_value_i,
  input  logic          end_of_line_i,
  output logic          item_valid_o,
  output xeu_pkg::item_t item_o,
  input  logic          pop_i
);
  import xeu_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      item_in;

  always_comb begin
    item_in.kind = end_of_line_i ? KIND_EOL : KIND_BYTE;
    item_in.data = byte_value_i;
    in_stall_o   = (cnt_q == 2'd2);
    push         = in_valid_i && !in_stall_o;
    item_valid_o = (cnt_q != 2'd0);
    item_o       = mem_q[rd_q];
    wr_d         = push ? ~wr_q : wr_q;
    rd_d         = pop_i ? ~rd_q : rd_q;
    cnt_d        = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/xeu_back.sv]
// Back end of the XML entity unescape unit: entity state machine, one
// byte per cycle unless blocked by the output stage, with a circular
// byte store that replays failed names. Depends on xeu_pkg.
module xeu_back #(
  parameter int unsigned MAX_NAME = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  xeu_pkg::item_t              item_i,
  output logic                        pop_o,
  input  logic [xeu_pkg::LIMIT_W-1:0] limit_i,
  input  logic                        block_i,
  output xeu_pkg::back_ctl_t          ctl_o
);
  import xeu_pkg::*;

  localparam int unsigned PtrW  = $clog2(MAX_NAME + 2);
  localparam int unsigned Depth = 2 ** PtrW;
  localparam int unsigned NlW   = $clog2(MAX_NAME + 1);

  logic [7:0]          name_buf_q [Depth];
  logic                pend_q, pend_d;
  logic [NlW-1:0]      nl_q, nl_d;
  logic [PtrW-1:0]     start_q, start_d, head_q, head_d, end_q, end_d;
  logic                hash_q, hash_d, hex_q, hex_d, stop_q, stop_d;
  logic [7:0]          acc_q, acc_d;
  logic [NAME_CNT-1:0] match_q, match_d;
  logic [LIMIT_W-1:0]  cnt_q, cnt_d;

  logic                replay, wr_en, emit, fail, marker, numeric, hit, done, fire;
  logic [7:0]          b, emit_data, hit_char;
  logic [PtrW-1:0]     next_pos;
  logic                hash_n, hex_n, stop_n;
  logic [7:0]          acc_n;
  logic [NAME_CNT-1:0] match_n;
  logic [11:0]         acc_mul, acc_sum;
  digit_t              dig;

  always_comb begin
    replay   = (head_q != end_q);
    b        = replay ? name_buf_q[head_q] : item_i.data;
    next_pos = replay ? head_q + PtrW'(1) : end_q;

    // name and numeric checks on the entity collected so far
    numeric  = hash_q && (nl_q >= NlW'(2));
    hit      = 1'b0;
    hit_char = 8'h00;
    for (int k = 0; k < NAME_CNT; k++) begin
      if (match_q[k] && (nl_q == NlW'(name_len(name_e'(k))))) begin
        hit      = 1'b1;
        hit_char = name_value(name_e'(k));
      end
    end

    // incremental decode of b at name position nl_q
    dig     = digit_of(b, hex_q);
    acc_mul = hex_q ? {acc_q, 4'b0000} : (({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1));
    acc_sum = acc_mul + {8'b0, dig.val};
    hash_n  = hash_q;
    hex_n   = hex_q;
    stop_n  = stop_q;
    acc_n   = acc_q;
    if (nl_q == '0) begin
      hash_n = (b == CH_HASH);
      hex_n  = 1'b0;
      stop_n = 1'b0;
      acc_n  = 8'h00;
      for (int k = 0; k < NAME_CNT; k++) begin
        match_n[k] = (b == name_char(name_e'(k), 2'd0));
      end
    end else begin
      for (int k = 0; k < NAME_CNT; k++) begin
        match_n[k] = match_q[k] && (nl_q < NlW'(name_len(name_e'(k))))
                     && (b == name_char(name_e'(k), nl_q[1:0]));
      end
      if (hash_q && (nl_q == NlW'(1)) && ((b == CH_LX) || (b == CH_UX))) begin
        hex_n = 1'b1;
      end else if (hash_q && !stop_q) begin
        if (!dig.ok) begin
          stop_n = 1'b1;
        end else begin
          acc_n = (acc_sum >= 12'(CODE_SAT)) ? CODE_SAT : acc_sum[7:0];
        end
      end
    end

    pend_d    = pend_q;
    nl_d      = nl_q;
    start_d   = start_q;
    head_d    = replay ? next_pos : head_q;
    end_d     = end_q;
    hash_d    = hash_q;
    hex_d     = hex_q;
    stop_d    = stop_q;
    acc_d     = acc_q;
    match_d   = match_q;
    wr_en     = 1'b0;
    emit      = 1'b0;
    emit_data = 8'h00;
    fail      = 1'b0;
    marker    = 1'b0;

    if (replay || (item_i.kind == KIND_BYTE)) begin
      if (!pend_q) begin
        if (b == CH_AMP) begin
          pend_d  = 1'b1;
          nl_d    = '0;
          start_d = next_pos;
        end else begin
          emit      = 1'b1;
          emit_data = b;
        end
      end else if (b == CH_SEMI) begin
        if (numeric) begin
          if ((acc_q == CODE_LF) || (acc_q == CODE_CR)) begin
            pend_d = 1'b0;
            nl_d   = '0;
          end else if ((acc_q != 8'h00) && (acc_q < CODE_SAT)) begin
            emit      = 1'b1;
            emit_data = acc_q;
            pend_d    = 1'b0;
            nl_d      = '0;
          end else begin
            fail = 1'b1;
          end
        end else if (hit) begin
          emit      = 1'b1;
          emit_data = hit_char;
          pend_d    = 1'b0;
          nl_d      = '0;
        end else begin
          fail = 1'b1;
        end
      end else if (nl_q < NlW'(MAX_NAME)) begin
        nl_d    = nl_q + NlW'(1);
        hash_d  = hash_n;
        hex_d   = hex_n;
        stop_d  = stop_n;
        acc_d   = acc_n;
        match_d = match_n;
        if (!replay) begin
          wr_en  = 1'b1;
          end_d  = end_q + PtrW'(1);
          head_d = head_q + PtrW'(1);
        end
      end else begin
        fail = 1'b1;
      end

      // failed entity: literal '&', then rescan from the first name byte
      if (fail) begin
        emit      = 1'b1;
        emit_data = CH_AMP;
        pend_d    = 1'b0;
        nl_d      = '0;
        head_d    = start_q;
        if (!replay) begin
          wr_en = 1'b1;
          end_d = end_q + PtrW'(1);
        end
      end
    end else if (pend_q) begin
      // line end with an open entity
      emit      = 1'b1;
      emit_data = CH_AMP;
      pend_d    = 1'b0;
      nl_d      = '0;
      head_d    = start_q;
    end else begin
      marker = 1'b1;
    end

    ctl_o.res_v          = marker || (emit && (cnt_q < limit_i));
    ctl_o.res.data       = marker ? 8'h00 : emit_data;
    ctl_o.res.byte_valid = !marker;
    ctl_o.res.line_done  = marker;

    if (marker) begin
      cnt_d = '0;
    end else if (emit && (cnt_q < limit_i)) begin
      cnt_d = cnt_q + LIMIT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end

    done       = (item_i.kind == KIND_BYTE) ? (head_d == end_d) : marker;
    fire       = item_valid_i && !block_i;
    ctl_o.fire = fire;
    ctl_o.done = done;
    pop_o      = fire && done;
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      name_buf_q[end_q] <= b;
    end
    if (fire) begin
      hash_q  <= hash_d;
      hex_q   <= hex_d;
      stop_q  <= stop_d;
      acc_q   <= acc_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      nl_q    <= '0;
      start_q <= '0;
      head_q  <= '0;
      end_q   <= '0;
      cnt_q   <= '0;
    end else if (fire) begin
      pend_q  <= pend_d;
      nl_q    <= nl_d;
      start_q <= start_d;
      head_q  <= head_d;
      end_q   <= end_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/xeu_out.sv]
// Output stage of the XML entity unescape unit: holds the newest result
// until its last flag is known, then moves it to the output register.
// Depends on xeu_pkg.
module xeu_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xeu_pkg::back_ctl_t ctl_i,
  output logic               block_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         byte_out_o,
  output logic               byte_valid_o,
  output logic               line_done_o,
  output logic               last_o
);
  import xeu_pkg::*;

  res_t hold_q, hold_d, out_q, out_d;
  logic hold_v_q, hold_v_d, hold_fin_q, hold_fin_d;
  logic out_v_q, out_v_d, out_last_q, out_last_d;
  logic out_free, move, take;

  always_comb begin
    out_free = !out_v_q || !out_stall_i;
    take     = ctl_i.fire && ctl_i.res_v;
    move     = hold_v_q && out_free && (hold_fin_q || take);
    block_o  = hold_v_q && ctl_i.res_v && !out_free;

    out_d      = move ? hold_q : out_q;
    out_last_d = move ? hold_fin_q : out_last_q;
    out_v_d    = move || (out_v_q && out_stall_i);

    hold_d     = hold_q;
    hold_v_d   = hold_v_q;
    hold_fin_d = hold_fin_q;
    if (take) begin
      hold_d     = ctl_i.res;
      hold_v_d   = 1'b1;
      hold_fin_d = ctl_i.done;
    end else if (move) begin
      hold_v_d = 1'b0;
    end else if (ctl_i.fire && ctl_i.done && hold_v_q) begin
      hold_fin_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q   <= 1'b0;
      hold_fin_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      hold_v_q   <= hold_v_d;
      hold_fin_q <= hold_fin_d;
      out_v_q    <= out_v_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign byte_out_o   = out_q.data;
  assign byte_valid_o = out_q.byte_valid;
  assign line_done_o  = out_q.line_done;
  assign last_o       = out_last_q;

endmodule

[test/xeu_unescape_checker.sv]
// Checker for xml_entity_unescape_unit: watches the input, output and limit
// ports, predicts the unescaped beats of every input beat and compares them.
// Depends on xeu_pkg.
module xeu_unescape_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [xeu_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [7:0]                  byte_value_i,
  input  logic                        end_of_line_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [7:0]                  byte_out_i,
  input  logic                        byte_valid_i,
  input  logic                        line_done_i,
  input  logic                        last_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import xeu_pkg::*;

  localparam int NAME_MAX   = 10;
  localparam int REPLAY_CAP = NAME_MAX + 1;

  typedef enum logic [1:0] {
    ENT_BAD,
    ENT_CHAR,
    ENT_SKIP
  } ent_result_e;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic       last;
  } out_beat_t;

  logic [LIMIT_W-1:0] limit_q;
  bit                 ent_open;
  logic [7:0]         name_buf [NAME_MAX];
  int                 name_len;
  int                 emitted;
  logic [7:0]         replay_q [$];
  out_beat_t          beat_out_q [$];
  out_beat_t          unescaped_q [$];

  task automatic report_mismatch(input string what);
    fail_count_o++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic push_beat(input logic [7:0] data, input logic valid, input logic done);
    out_beat_t ob;
    ob = '{data: data, valid: valid, done: done, last: 1'b0};
    beat_out_q.push_back(ob);
  endtask

  task automatic emit_char(input logic [7:0] c);
    if (emitted < limit_q) begin
      push_beat(c, 1'b1, 1'b0);
      emitted++;
    end
  endtask

  function automatic int digit_val(input logic [7:0] c, input bit hex);
    if (c >= "0" && c <= "9") return c - "0";
    if (hex && c >= "a" && c <= "f") return c - "a" + 10;
    if (hex && c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit name_is(input string s);
    if (name_len != s.len()) return 1'b0;
    for (int k = 0; k < s.len(); k++) begin
      if (name_buf[k] != s[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic ent_result_e decode_name(output logic [7:0] ch);
    int base;
    int pos;
    int acc;
    int d;
    bit hex;
    ch = 8'h00;
    if (name_len >= 2 && name_buf[0] == CH_HASH) begin
      hex  = (name_buf[1] == CH_LX || name_buf[1] == CH_UX);
      base = hex ? 16 : 10;
      pos  = hex ? 2 : 1;
      acc  = 0;
      d    = 0;
      while (pos < name_len && d >= 0) begin
        d = digit_val(name_buf[pos], hex);
        if (d >= 0) begin
          acc = acc * base + d;
          if (acc >= CODE_SAT) acc = CODE_SAT;
        end
        pos++;
      end
      if (acc == CODE_LF || acc == CODE_CR) return ENT_SKIP;
      if (acc >= 1 && acc < CODE_SAT) begin
        ch = acc[7:0];
        return ENT_CHAR;
      end
      return ENT_BAD;
    end
    if (name_is("amp")) begin ch = "&"; return ENT_CHAR; end
    if (name_is("lt")) begin ch = "<"; return ENT_CHAR; end
    if (name_is("gt")) begin ch = ">"; return ENT_CHAR; end
    if (name_is("quot")) begin ch = "\""; return ENT_CHAR; end
    if (name_is("apos")) begin ch = "'"; return ENT_CHAR; end
    return ENT_BAD;
  endfunction

  // Feeds replay_q through the entity state; a failed entity pushes its
  // buffered name and the terminating byte back to the head for rescan.
  task automatic run_replay();
    logic [7:0]  b;
    logic [7:0]  ch;
    logic [7:0]  rescan [$];
    ent_result_e res;
    while (replay_q.size() > 0) begin
      b = replay_q.pop_front();
      if (!ent_open) begin
        if (b == CH_AMP) begin
          ent_open = 1'b1;
          name_len = 0;
        end else begin
          emit_char(b);
        end
      end else if (b != CH_SEMI && name_len < NAME_MAX) begin
        name_buf[name_len] = b;
        name_len++;
      end else begin
        res = ENT_BAD;
        if (b == CH_SEMI) res = decode_name(ch);
        if (res == ENT_CHAR) begin
          emit_char(ch);
          ent_open = 1'b0;
          name_len = 0;
        end else if (res == ENT_SKIP) begin
          ent_open = 1'b0;
          name_len = 0;
        end else begin
          emit_char(CH_AMP);
          ent_open = 1'b0;
          rescan = {};
          for (int k = 0; k < name_len; k++) rescan.push_back(name_buf[k]);
          rescan.push_back(b);
          while (replay_q.size() > 0 && rescan.size() < REPLAY_CAP)
            rescan.push_back(replay_q.pop_front());
          replay_q = rescan;
          name_len = 0;
        end
      end
    end
  endtask

  task automatic predict_beat(input logic [7:0] b, input item_kind_e kind);
    out_beat_t ob;
    beat_out_q = {};
    if (kind == KIND_BYTE) begin
      replay_q = {b};
      run_replay();
    end else begin
      while (ent_open) begin
        emit_char(CH_AMP);
        ent_open = 1'b0;
        replay_q = {};
        for (int k = 0; k < name_len; k++) replay_q.push_back(name_buf[k]);
        name_len = 0;
        run_replay();
      end
      push_beat(8'h00, 1'b0, 1'b1);
      ent_open = 1'b0;
      name_len = 0;
      emitted  = 0;
    end
    for (int k = 0; k < beat_out_q.size(); k++) begin
      ob = beat_out_q[k];
      ob.last = (k == beat_out_q.size() - 1);
      unescaped_q.push_back(ob);
    end
  endtask

  task automatic check_beat();
    out_beat_t want;
    if (unescaped_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat byte %02h valid %b done %b last %b",
                                byte_out_i, byte_valid_i, line_done_i, last_i));
      return;
    end
    want = unescaped_q.pop_front();
    if (byte_out_i !== want.data || byte_valid_i !== want.valid ||
        line_done_i !== want.done || last_i !== want.last)
      report_mismatch($sformatf("got byte %02h valid %b done %b last %b, want %02h %b %b %b",
                                byte_out_i, byte_valid_i, line_done_i, last_i,
                                want.data, want.valid, want.done, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      = LIMIT_RST;
      ent_open     = 1'b0;
      name_len     = 0;
      emitted      = 0;
      unescaped_q  = {};
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        predict_beat(byte_value_i, end_of_line_i ? KIND_EOL : KIND_BYTE);
      if (out_valid_i && !out_stall_i) check_beat();
      pending_o <= unescaped_q.size();
    end
  end

endmodule

[test/tb_xml_entity_unescape_unit.sv]
// Testbench top for xml_entity_unescape_unit: clock, reset, limit writes,
// directed and random escaped text with sender gaps and receiver stalls.
// Depends on xeu_pkg, xml_entity_unescape_unit and xeu_unescape_checker.
module tb_xml_entity_unescape_unit;
  import xeu_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_ITEMS   = 66;
  localparam int PHASE_CNT     = 6;
  localparam logic [7:0] LOW_A = 8'h61;
  localparam logic [7:0] LOW_Z = 8'h7A;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [7:0]         byte_value_i  = 8'h00;
  logic               end_of_line_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [7:0]         byte_out_o;
  logic               byte_valid_o;
  logic               line_done_o;
  logic               last_o;

  int   mismatches;
  int   pending_results;
  int   cycles     = 0;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  logic hold_req   = 1'b0;
  logic hold_prev;
  int   hold_left;
  int   items_sent = 0;
  int   phase_start;

  logic [7:0]         text_q [$];
  string              entity_names [5] = '{"amp", "lt", "gt", "quot", "apos"};
  string              odd_numerics [7] = '{"&#10;", "&#13;", "&#x;", "&#;", "&#128;",
                                           "&#x0a;", "&#0;"};
  logic [LIMIT_W-1:0] phase_limit  [PHASE_CNT] = '{10'd319, 10'd0, 10'd1023, 10'd6,
                                                   10'd1023, 10'd25};
  int                 phase_idle   [PHASE_CNT] = '{0, 59, 0, 27, 0, 59};
  int                 phase_stall  [PHASE_CNT] = '{0, 0, 59, 27, 0, 59};

  xml_entity_unescape_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_value_i  (byte_value_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_out_o    (byte_out_o),
    .byte_valid_o  (byte_valid_o),
    .line_done_o   (line_done_o),
    .last_o        (last_o)
  );

  xeu_unescape_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .byte_value_i  (byte_value_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_out_i    (byte_out_o),
    .byte_valid_i  (byte_valid_o),
    .line_done_i   (line_done_o),
    .last_i        (last_o),
    .fail_count_o  (mismatches),
    .pending_o     (pending_results)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off per rise of hold_req
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left    = 0;
      hold_prev    = 1'b0;
    end else begin
      if (hold_req && !hold_prev) hold_left = HOLD_CYCLES;
      hold_prev = hold_req;
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // valid stays high on return; the caller drives the next beat or drains
  task automatic send_beat(input logic [7:0] b, input logic eol);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    byte_value_i  <= b;
    end_of_line_i <= eol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endtask

  task automatic send_text(input string s);
    push_text(s);
    while (text_q.size() > 0) send_beat(text_q.pop_front(), 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    hold_req   <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_random_piece();
    int    pick;
    int    n;
    int    v;
    string digits;
    text_q = {};
    pick   = $urandom_range(99);
    if (pick < 6) begin
      send_beat(8'($urandom_range(255)), 1'b1);
      return;
    end
    if (pick < 28) begin
      n = $urandom_range(1, 4);
      repeat (n) text_q.push_back(8'($urandom_range(255)));
    end else if (pick < 48) begin
      text_q.push_back(CH_AMP);
      push_text(entity_names[$urandom_range(4)]);
      if ($urandom_range(9) == 0) text_q[1] = text_q[1] ^ 8'h20;
      if ($urandom_range(9) != 0) text_q.push_back(CH_SEMI);
    end else if (pick < 62) begin
      v = $urandom_range(300);
      push_text("&#");
      if ($urandom_range(4) == 0) text_q.push_back("0");
      if ($urandom_range(15) != 0) push_text($sformatf("%0d", v));
      if ($urandom_range(9) == 0) text_q.push_back("z");
      text_q.push_back(CH_SEMI);
    end else if (pick < 74) begin
      v = $urandom_range(255);
      text_q.push_back(CH_AMP);
      text_q.push_back(CH_HASH);
      text_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
      digits = $sformatf("%0h", v);
      for (int k = 0; k < digits.len(); k++)
        text_q.push_back((digits[k] >= "a" && $urandom_range(1)) ? digits[k] ^ 8'h20
                                                                  : digits[k]);
      if ($urandom_range(9) == 0) text_q.push_back("g");
      text_q.push_back(CH_SEMI);
    end else if (pick < 84) begin
      n = $urandom_range(7, 12);
      text_q.push_back(CH_AMP);
      repeat (n) text_q.push_back(8'($urandom_range(LOW_Z, LOW_A)));
      if ($urandom_range(1)) text_q.push_back(CH_SEMI);
    end else if (pick < 94) begin
      text_q.push_back(CH_AMP);
      repeat ($urandom_range(3)) text_q.push_back(8'($urandom_range(LOW_Z, LOW_A)));
      text_q.push_back(CH_AMP);
      push_text(entity_names[$urandom_range(4)]);
      text_q.push_back(CH_SEMI);
    end else begin
      push_text(odd_numerics[$urandom_range(6)]);
    end
    while (text_q.size() > 0) send_beat(text_q.pop_front(), 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte extremes, named and dropped entities, open entity at
    // line end with a nested '&', then a line cut by the output limit
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h7F, 1'b0);
    send_text("&amp;");
    send_text("&#13;");
    send_text("&q&gt");
    send_beat(8'hFF, 1'b1);
    drain();
    set_limit(10'd1);
    send_text("ab");
    send_beat(8'h00, 1'b1);

    for (int p = 0; p < PHASE_CNT; p++) begin
      drain();
      set_limit(phase_limit[p]);
      idle_pct   = phase_idle[p];
      stall_pct <= phase_stall[p];
      if (p == 0 || p == 3) hold_req <= 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_piece();
    end
    send_beat(8'($urandom_range(255)), 1'b1);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/xeu_pkg.sv
rtl/xeu_front.sv
rtl/xeu_back.sv
rtl/xeu_out.sv
rtl/xml_entity_unescape_unit.sv
test/xeu_unescape_checker.sv
test/tb_xml_entity_unescape_unit.sv
